// File: rtl/first_fit_bitmap_allocator_macros.svh
// Assertion macros for the first-fit bitmap allocator.
// Included by the top level; depends on nothing else.
`ifndef FIRST_FIT_BITMAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BITMAP_ALLOCATOR_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define FFBA_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define FFBA_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ffba_pkg.sv
// Shared types and constants of the first-fit bitmap allocator.
// Used by ffba_scan and the top level; depends on nothing.
package ffba_pkg;

    localparam int CNT_W  = 14;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] RESET_VALID_BITS = 14'd8192;

    localparam logic [1:0] OP_LOAD_WORD   = 2'd0;
    localparam logic [1:0] OP_LOAD_COUNTS = 2'd1;
    localparam logic [1:0] OP_ALLOCATE    = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [IDX_W-1:0]  word_index;
        logic [DATA_W-1:0] word_data;
        logic [CNT_W-1:0]  super_count;
        logic [CNT_W-1:0]  group_count;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [CNT_W-1:0]  entry_number;
        logic [IDX_W-1:0]  changed_index;
        logic [DATA_W-1:0] changed_data;
        logic [CNT_W-1:0]  super_free;
        logic [CNT_W-1:0]  group_free;
    } t_out_item;

    typedef struct packed {
        logic hit;
        logic last;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_SCAN  = 3'b100
    } t_state;

endpackage

// File: rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the bitmap words; depends on nothing.
module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ffba_scan.sv
// Word checker: lowest clear bit below the limit, and the word with it set.
// Depends on ffba_pkg for the flag struct.
module ffba_scan #(
    parameter int WORD_BITS = 32,
    parameter int LW        = 15
) (
    input  logic [WORD_BITS-1:0]                              i_word,
    input  logic [LW-1:0]                                     i_base,
    input  logic [LW-1:0]                                     i_limit,
    output ffba_pkg::t_scan_flags                             o_flags,
    output logic [(WORD_BITS > 1 ? $clog2(WORD_BITS) : 1)-1:0] o_bit,
    output logic [WORD_BITS-1:0]                              o_word
);
    import ffba_pkg::*;

    localparam int BIW = WORD_BITS > 1 ? $clog2(WORD_BITS) : 1;

    logic [LW-1:0]        w_rem;
    logic [LW-1:0]        w_end;
    logic [WORD_BITS-1:0] w_free;
    logic [BIW-1:0]       w_bit;

    assign w_rem = (i_limit > i_base) ? (i_limit - i_base) : '0;
    assign w_end = i_base + LW'(WORD_BITS);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_free[b] = !i_word[b] && (LW'(b) < w_rem);
        end
    end

    always_comb begin
        w_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_bit = BIW'(b);
            end
        end
    end

    assign o_flags.hit  = |w_free;
    assign o_flags.last = w_end >= i_limit;
    assign o_bit        = w_bit;
    assign o_word       = i_word | (WORD_BITS'(1) << w_bit);

endmodule

// File: rtl/first_fit_bitmap_allocator.sv
// Top level of the first-fit bitmap allocator: control, counters, output register.
// Depends on ffba_pkg, ffba_ram, ffba_scan and first_fit_bitmap_allocator_macros.svh.
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_in_item  | item in
//  out     | o_out_valid, i_out_stall, o_out_item| item out
//  cfg     | i_cfg_we, i_cfg_data               | valid_bits write
//
// A load item is written to the output register on acceptance. An allocate item checks
// bitmap words in turn (up to MAP_BITS/WORD_BITS), one RAM read per cycle.
// After reset the RAM is cleared one word per cycle, all MAP_BITS/WORD_BITS words,
// with the input stalled. One item is in flight at a time; a result that waits
// on a stalled output holds the input stalled.
module first_fit_bitmap_allocator #(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffba_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ffba_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ffba_pkg::t_out_item         o_out_item
);
    import ffba_pkg::*;

`include "first_fit_bitmap_allocator_macros.svh"

    localparam int NWORDS = MAP_BITS / WORD_BITS;
    localparam int WIDX   = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int CW     = $clog2(MAP_BITS + 1);
    localparam int LW     = (CW > CNT_W ? CW : CNT_W) + 1;
    localparam int BIW    = WORD_BITS > 1 ? $clog2(WORD_BITS) : 1;

    localparam logic [WIDX-1:0] LAST_ADDR = WIDX'(NWORDS - 1);
    localparam logic [LW-1:0]   MAP_LIM   = LW'(MAP_BITS);
    localparam logic [LW-1:0]   WORD_STEP = LW'(WORD_BITS);

    t_state               r_state,     n_state;
    logic [CNT_W-1:0]     r_valid_bits;
    logic [CNT_W-1:0]     r_super,     n_super;
    logic [CNT_W-1:0]     r_group,     n_group;
    logic [WIDX-1:0]      r_clr_addr,  n_clr_addr;
    logic [WIDX-1:0]      r_rd_addr,   n_rd_addr;
    logic [LW-1:0]        r_rd_base,   n_rd_base;
    logic                 r_chk_valid, n_chk_valid;
    logic [WIDX-1:0]      r_chk_addr,  n_chk_addr;
    logic [LW-1:0]        r_chk_base,  n_chk_base;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item,  n_out_item;

    logic                 w_accept;
    logic [LW-1:0]        w_limit;
    logic [LW-1:0]        w_entry;
    logic                 w_ram_we;
    logic [WIDX-1:0]      w_ram_waddr;
    logic [WORD_BITS-1:0] w_ram_wdata;
    logic [WORD_BITS-1:0] w_ram_rdata;
    t_scan_flags          w_flags;
    logic [BIW-1:0]       w_bit;
    logic [WORD_BITS-1:0] w_new_word;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_limit = (LW'(r_valid_bits) > MAP_LIM) ? MAP_LIM : LW'(r_valid_bits);
    assign w_entry = r_chk_base + LW'(w_bit) + LW'(1);

    ffba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    ffba_scan #(
        .WORD_BITS (WORD_BITS),
        .LW        (LW)
    ) u_scan (
        .i_word  (w_ram_rdata),
        .i_base  (r_chk_base),
        .i_limit (w_limit),
        .o_flags (w_flags),
        .o_bit   (w_bit),
        .o_word  (w_new_word)
    );

    always_comb begin
        n_state     = r_state;
        n_super     = r_super;
        n_group     = r_group;
        n_clr_addr  = r_clr_addr;
        n_rd_addr   = r_rd_addr;
        n_rd_base   = r_rd_base;
        n_chk_valid = 1'b0;
        n_chk_addr  = r_rd_addr;
        n_chk_base  = r_rd_base;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr_addr;
        w_ram_wdata = '0;

        case (r_state)
            ST_CLEAR: begin
                w_ram_we   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_item            = '0;
                    n_out_item.super_free = r_super;
                    n_out_item.group_free = r_group;
                    case (i_in_item.operation)
                        OP_LOAD_WORD: begin
                            n_out_valid = 1'b1;
                            if (32'(i_in_item.word_index) < 32'(NWORDS)) begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = WIDX'(i_in_item.word_index);
                                w_ram_wdata = WORD_BITS'(i_in_item.word_data);
                            end
                        end
                        OP_LOAD_COUNTS: begin
                            n_out_valid           = 1'b1;
                            n_super               = i_in_item.super_count;
                            n_group               = i_in_item.group_count;
                            n_out_item.super_free = i_in_item.super_count;
                            n_out_item.group_free = i_in_item.group_count;
                        end
                        OP_ALLOCATE: begin
                            n_state   = ST_SCAN;
                            n_rd_addr = '0;
                            n_rd_base = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_chk_valid = 1'b1;
                if (r_rd_addr != LAST_ADDR) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_rd_base = r_rd_base + WORD_STEP;
                end
                if (r_chk_valid) begin
                    if (w_flags.hit) begin
                        w_ram_we                 = 1'b1;
                        w_ram_waddr              = r_chk_addr;
                        w_ram_wdata              = w_new_word;
                        n_super                  = (r_super == '0) ? '0 : r_super - 1'b1;
                        n_group                  = (r_group == '0) ? '0 : r_group - 1'b1;
                        n_out_item.found         = 1'b1;
                        n_out_item.entry_number  = w_entry[CNT_W-1:0];
                        n_out_item.changed_index = IDX_W'(r_chk_addr);
                        n_out_item.changed_data  = DATA_W'(w_new_word);
                        n_out_item.super_free    = n_super;
                        n_out_item.group_free    = n_group;
                        n_out_valid              = 1'b1;
                        n_chk_valid              = 1'b0;
                        n_state                  = ST_IDLE;
                    end else if (w_flags.last) begin
                        n_out_item.found         = 1'b0;
                        n_out_item.entry_number  = '0;
                        n_out_item.changed_index = '0;
                        n_out_item.changed_data  = '0;
                        n_out_item.super_free    = r_super;
                        n_out_item.group_free    = r_group;
                        n_out_valid              = 1'b1;
                        n_chk_valid              = 1'b0;
                        n_state                  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_valid_bits <= RESET_VALID_BITS;
            r_super      <= '0;
            r_group      <= '0;
            r_clr_addr   <= '0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_super     <= n_super;
            r_group     <= n_group;
            r_clr_addr  <= n_clr_addr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_valid_bits <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_rd_base  <= n_rd_base;
        r_chk_addr <= n_chk_addr;
        r_chk_base <= n_chk_base;
        r_out_item <= n_out_item;
    end

    `FFBA_CHECK_NEXT(a_hit_ends_scan, i_clk, i_rst_n,
        (r_state == ST_SCAN) && r_chk_valid && w_flags.hit,
        (r_state == ST_IDLE) && r_out_valid && r_out_item.found,
        "allocation hit did not end the scan with a result")

    `FFBA_CHECK_NEXT(a_scan_no_count_rise, i_clk, i_rst_n,
        r_state == ST_SCAN,
        (r_super <= $past(r_super)) && (r_group <= $past(r_group)),
        "free counter rose during a scan")

    `FFBA_CHECK(a_scan_within_limit, i_clk, i_rst_n,
        (r_state == ST_SCAN) && r_chk_valid,
        (r_chk_base < w_limit) || (r_chk_base == '0),
        "scan read a word past the valid bits")

endmodule
